// File: design/rgbac_pkg.sv
// Shared types, codes and calibration helpers for the RGB average color classifier.
package rgbac_pkg;

    localparam int SAMPLES_PER_RUN_DEF = 8;
    localparam int RAW_W  = 16;
    localparam int SUM_W  = 24;
    localparam int AVG_W  = 16;
    localparam int MASK_W = 9;
    localparam int CFG_W  = 9;

    // configuration register indexes
    localparam logic CFG_SORT_ENABLED = 1'b0;
    localparam logic CFG_LEFT_MASK    = 1'b1;

    // color codes
    localparam logic [3:0] COLOR_RED    = 4'd0;
    localparam logic [3:0] COLOR_GREEN  = 4'd1;
    localparam logic [3:0] COLOR_BLUE   = 4'd2;
    localparam logic [3:0] COLOR_BLACK  = 4'd3;
    localparam logic [3:0] COLOR_WHITE  = 4'd4;
    localparam logic [3:0] COLOR_ORANGE = 4'd5;
    localparam logic [3:0] COLOR_YELLOW = 4'd6;
    localparam logic [3:0] COLOR_PURPLE = 4'd7;
    localparam logic [3:0] COLOR_BROWN  = 4'd8;
    localparam logic [3:0] COLOR_ABSENT = 4'd9;

    // steering codes
    localparam logic [1:0] DIR_CENTER = 2'd0;
    localparam logic [1:0] DIR_LEFT   = 2'd1;
    localparam logic [1:0] DIR_RIGHT  = 2'd2;

    typedef struct packed {
        logic [RAW_W-1:0] red_raw;
        logic [RAW_W-1:0] green_raw;
        logic [RAW_W-1:0] blue_raw;
    } t_in_req;

    typedef struct packed {
        logic [3:0]       color_code;
        logic [1:0]       direction;
        logic [AVG_W-1:0] avg_red;
        logic [AVG_W-1:0] avg_green;
        logic [AVG_W-1:0] avg_blue;
        logic             sorting_active;
    } t_out_res;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } t_sums;

    typedef struct packed {
        logic [AVG_W-1:0] red;
        logic [AVG_W-1:0] green;
        logic [AVG_W-1:0] blue;
    } t_avgs;

    typedef struct packed {
        logic             sort_enabled;
        logic [MASK_W-1:0] left_mask;
    } t_cfg;

    // open window: strictly between the bounds
    function automatic logic in_win(input logic [AVG_W-1:0] v,
                                    input logic [AVG_W-1:0] lo,
                                    input logic [AVG_W-1:0] hi);
        return (v > lo) && (v < hi);
    endfunction

    // first matching window in priority order
    function automatic logic [3:0] classify(input logic [AVG_W-1:0] r,
                                            input logic [AVG_W-1:0] g,
                                            input logic [AVG_W-1:0] b);
        logic [3:0] code;
        code = COLOR_ABSENT;
        if (r >= 16'd50000 && in_win(g, 16'd21000, 16'd26000)
                && in_win(b, 16'd21000, 16'd26000))
            code = COLOR_RED;
        else if (in_win(r, 16'd9000, 16'd13000) && in_win(g, 16'd31000, 16'd36500)
                && in_win(b, 16'd30000, 16'd35000))
            code = COLOR_GREEN;
        else if (in_win(r, 16'd10500, 16'd15000) && in_win(g, 16'd46000, 16'd52500)
                && b > 16'd63000)
            code = COLOR_BLUE;
        else if ((in_win(r, 16'd7000, 16'd11000) && in_win(g, 16'd12000, 16'd16500)
                    && in_win(b, 16'd17500, 16'd22000))
                || (in_win(r, 16'd5500, 16'd8500) && in_win(g, 16'd9000, 16'd12000)
                    && in_win(b, 16'd11000, 16'd15000)))
            code = COLOR_BLACK;
        else if ((r > 16'd62000 && g > 16'd64500 && b > 16'd64500)
                || (in_win(r, 16'd25000, 16'd33000) && in_win(g, 16'd33000, 16'd44000)
                    && b > 16'd50000))
            code = COLOR_WHITE;
        else if (r > 16'd57000 && in_win(g, 16'd22500, 16'd27500)
                && in_win(b, 16'd16000, 16'd23500))
            code = COLOR_ORANGE;
        else if (r > 16'd65000 && g > 16'd65000 && in_win(b, 16'd35000, 16'd39000))
            code = COLOR_YELLOW;
        else if (r > 16'd48000 && in_win(g, 16'd21000, 16'd27500)
                && in_win(b, 16'd31000, 16'd37500))
            code = COLOR_PURPLE;
        else if (in_win(r, 16'd12000, 16'd17000) && in_win(g, 16'd14000, 16'd18500)
                && in_win(b, 16'd17000, 16'd23500))
            code = COLOR_BROWN;
        return code;
    endfunction

endpackage

// File: design/rgbac_accum.sv
// Sample accumulator: byte-swaps raw words, sums a run and hands off finished sums.
module rgbac_accum #(
    parameter int SAMPLES_PER_RUN = rgbac_pkg::SAMPLES_PER_RUN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  rgbac_pkg::t_in_req i_req,
    output logic               o_valid,
    input  logic               i_ready,
    output rgbac_pkg::t_sums   o_sums
);

    localparam int IDX_W = (SAMPLES_PER_RUN > 1) ? $clog2(SAMPLES_PER_RUN) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES_PER_RUN - 1);
    localparam int SUM_W = rgbac_pkg::SUM_W;

    rgbac_pkg::t_sums r_sums, n_sums;
    rgbac_pkg::t_sums r_fin;
    logic [IDX_W-1:0] r_idx;
    logic             r_fin_valid;
    logic             w_accept;
    logic             w_last;

    assign o_ready  = !r_fin_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_last   = (r_idx == LAST_IDX);
    assign o_valid  = r_fin_valid;
    assign o_sums   = r_fin;

    always_comb begin
        n_sums.red   = r_sums.red
                     + SUM_W'({i_req.red_raw[7:0], i_req.red_raw[15:8]});
        n_sums.green = r_sums.green
                     + SUM_W'({i_req.green_raw[7:0], i_req.green_raw[15:8]});
        n_sums.blue  = r_sums.blue
                     + SUM_W'({i_req.blue_raw[7:0], i_req.blue_raw[15:8]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sums      <= '0;
            r_idx       <= '0;
            r_fin_valid <= 1'b0;
        end else begin
            if (r_fin_valid && i_ready)
                r_fin_valid <= 1'b0;
            if (w_accept) begin
                if (w_last) begin
                    r_sums      <= '0;
                    r_idx       <= '0;
                    r_fin_valid <= 1'b1;
                end else begin
                    r_sums <= n_sums;
                    r_idx  <= r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_last)
            r_fin <= n_sums;
    end

endmodule

// File: design/rgbac_divide.sv
// Constant divider: sums times a reciprocal of the run length, registered averages.
module rgbac_divide #(
    parameter int SAMPLES_PER_RUN = rgbac_pkg::SAMPLES_PER_RUN_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  rgbac_pkg::t_sums i_sums,
    output logic             o_valid,
    input  logic             i_ready,
    output rgbac_pkg::t_avgs o_avgs
);

    localparam int SUM_W  = rgbac_pkg::SUM_W;
    localparam int AVG_W  = rgbac_pkg::AVG_W;
    localparam int MUL_W  = SUM_W + 2;
    localparam int PROD_W = SUM_W + MUL_W;
    // exact for every sum below 2**SUM_W
    localparam int SHIFT  = SUM_W + $clog2(SAMPLES_PER_RUN);
    localparam longint unsigned RECIP_L =
        ((64'd1 << SHIFT) + longint'(SAMPLES_PER_RUN) - 1) / longint'(SAMPLES_PER_RUN);
    localparam logic [MUL_W-1:0] RECIP = MUL_W'(RECIP_L);

    logic [PROD_W-1:0] w_prod_r, w_prod_g, w_prod_b;
    rgbac_pkg::t_avgs  r_avgs;
    logic              r_valid;
    logic              w_accept;

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign o_valid  = r_valid;
    assign o_avgs   = r_avgs;

    assign w_prod_r = PROD_W'(i_sums.red)   * PROD_W'(RECIP);
    assign w_prod_g = PROD_W'(i_sums.green) * PROD_W'(RECIP);
    assign w_prod_b = PROD_W'(i_sums.blue)  * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // quotient truncated to the average width
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_avgs.red   <= w_prod_r[SHIFT +: AVG_W];
            r_avgs.green <= w_prod_g[SHIFT +: AVG_W];
            r_avgs.blue  <= w_prod_b[SHIFT +: AVG_W];
        end
    end

endmodule

// File: design/rgbac_classify.sv
// Window classifier and steering, with the result register.
module rgbac_classify (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  rgbac_pkg::t_avgs    i_avgs,
    input  rgbac_pkg::t_cfg     i_cfg,
    output logic                o_valid,
    input  logic                i_ready,
    output rgbac_pkg::t_out_res o_res
);

    rgbac_pkg::t_out_res r_res, n_res;
    logic [3:0]          w_code;
    logic [rgbac_pkg::MASK_W-1:0] w_shifted;
    logic                r_valid;
    logic                w_accept;

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign o_valid  = r_valid;
    assign o_res    = r_res;

    assign w_code    = rgbac_pkg::classify(i_avgs.red, i_avgs.green, i_avgs.blue);
    assign w_shifted = i_cfg.left_mask >> w_code;

    always_comb begin
        n_res.avg_red        = i_avgs.red;
        n_res.avg_green      = i_avgs.green;
        n_res.avg_blue       = i_avgs.blue;
        n_res.sorting_active = i_cfg.sort_enabled;
        n_res.color_code     = rgbac_pkg::COLOR_ABSENT;
        n_res.direction      = rgbac_pkg::DIR_CENTER;
        if (i_cfg.sort_enabled) begin
            n_res.color_code = w_code;
            if (w_code != rgbac_pkg::COLOR_ABSENT)
                n_res.direction = w_shifted[0] ? rgbac_pkg::DIR_LEFT : rgbac_pkg::DIR_RIGHT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept)
            r_res <= n_res;
    end

endmodule

// File: design/rgb_average_color_classifier.sv
// Top level: accumulate a run of RGB samples, average, classify and steer.
// Throughput: one sample request per cycle, sustained, while the output is taken.
// Path: after its last sample is accepted, the result of a run passes through the
// sum register, the reciprocal multiply register and the classify/result register.
// Reset (synchronous, active low) clears the sums, the sample count, both config
// registers and all stage valids; no result is pending after reset.
module rgb_average_color_classifier #(
    parameter int SAMPLES_PER_RUN = rgbac_pkg::SAMPLES_PER_RUN_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  rgbac_pkg::t_in_req         i_in_req,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output rgbac_pkg::t_out_res        o_out_res,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [rgbac_pkg::CFG_W-1:0] i_cfg_data
);

    rgbac_pkg::t_cfg  r_cfg;
    rgbac_pkg::t_sums w_sums;
    rgbac_pkg::t_avgs w_avgs;
    logic             w_sums_valid, w_sums_ready;
    logic             w_avgs_valid, w_avgs_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rgbac_pkg::CFG_SORT_ENABLED: r_cfg.sort_enabled <= i_cfg_data[0];
                rgbac_pkg::CFG_LEFT_MASK:    r_cfg.left_mask <= i_cfg_data[rgbac_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    rgbac_accum #(
        .SAMPLES_PER_RUN(SAMPLES_PER_RUN)
    ) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_req   (i_in_req),
        .o_valid (w_sums_valid),
        .i_ready (w_sums_ready),
        .o_sums  (w_sums)
    );

    rgbac_divide #(
        .SAMPLES_PER_RUN(SAMPLES_PER_RUN)
    ) u_divide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sums_valid),
        .o_ready (w_sums_ready),
        .i_sums  (w_sums),
        .o_valid (w_avgs_valid),
        .i_ready (w_avgs_ready),
        .o_avgs  (w_avgs)
    );

    rgbac_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_avgs_valid),
        .o_ready (w_avgs_ready),
        .i_avgs  (w_avgs),
        .i_cfg   (r_cfg),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (o_out_res)
    );

endmodule

// File: tb/rgb_average_color_classifier_tb.sv
// Testbench for rgb_average_color_classifier: random sample runs against a run-level predictor.

localparam int RUN_LEN     = rgbac_pkg::SAMPLES_PER_RUN_DEF;
localparam int NUM_WINDOWS = 11;

// calibration window with inclusive bounds per channel
typedef struct packed {
    logic [3:0]  color;
    logic [15:0] r_lo;
    logic [15:0] r_hi;
    logic [15:0] g_lo;
    logic [15:0] g_hi;
    logic [15:0] b_lo;
    logic [15:0] b_hi;
} t_calib_window;

// windows in priority order; open bounds are stored as the closed range inside them
function automatic t_calib_window calib_window(int w);
    t_calib_window cw;
    cw = '0;
    cw.color = rgbac_pkg::COLOR_ABSENT;
    case (w)
        0:  cw = '{rgbac_pkg::COLOR_RED, 16'd50000, 16'd65535,
                   16'd21001, 16'd25999, 16'd21001, 16'd25999};
        1:  cw = '{rgbac_pkg::COLOR_GREEN, 16'd9001, 16'd12999,
                   16'd31001, 16'd36499, 16'd30001, 16'd34999};
        2:  cw = '{rgbac_pkg::COLOR_BLUE, 16'd10501, 16'd14999,
                   16'd46001, 16'd52499, 16'd63001, 16'd65535};
        3:  cw = '{rgbac_pkg::COLOR_BLACK, 16'd7001, 16'd10999,
                   16'd12001, 16'd16499, 16'd17501, 16'd21999};
        4:  cw = '{rgbac_pkg::COLOR_BLACK, 16'd5501, 16'd8499,
                   16'd9001, 16'd11999, 16'd11001, 16'd14999};
        5:  cw = '{rgbac_pkg::COLOR_WHITE, 16'd62001, 16'd65535,
                   16'd64501, 16'd65535, 16'd64501, 16'd65535};
        6:  cw = '{rgbac_pkg::COLOR_WHITE, 16'd25001, 16'd32999,
                   16'd33001, 16'd43999, 16'd50001, 16'd65535};
        7:  cw = '{rgbac_pkg::COLOR_ORANGE, 16'd57001, 16'd65535,
                   16'd22501, 16'd27499, 16'd16001, 16'd23499};
        8:  cw = '{rgbac_pkg::COLOR_YELLOW, 16'd65001, 16'd65535,
                   16'd65001, 16'd65535, 16'd35001, 16'd38999};
        9:  cw = '{rgbac_pkg::COLOR_PURPLE, 16'd48001, 16'd65535,
                   16'd21001, 16'd27499, 16'd31001, 16'd37499};
        10: cw = '{rgbac_pkg::COLOR_BROWN, 16'd12001, 16'd16999,
                   16'd14001, 16'd18499, 16'd17001, 16'd23499};
        default: ;
    endcase
    return cw;
endfunction

function automatic logic [15:0] swap16(logic [15:0] w);
    return {w[7:0], w[15:8]};
endfunction

function automatic logic [3:0] classify_avg(logic [15:0] r, logic [15:0] g, logic [15:0] b);
    t_calib_window cw;
    int w;
    for (w = 0; w < NUM_WINDOWS; w++) begin
        cw = calib_window(w);
        if (r >= cw.r_lo && r <= cw.r_hi && g >= cw.g_lo && g <= cw.g_hi
                && b >= cw.b_lo && b <= cw.b_hi)
            return cw.color;
    end
    return rgbac_pkg::COLOR_ABSENT;
endfunction

class color_run_scoreboard;
    logic        sort_en;
    logic [8:0]  left_mask;
    logic [23:0] sum_r;
    logic [23:0] sum_g;
    logic [23:0] sum_b;
    int          taken;
    rgbac_pkg::t_out_res expected_runs[$];
    int          errors;
    int          samples;
    int          results;
    int          unsorted;
    int          per_color[16];

    function new();
        sort_en   = 1'b0;
        left_mask = '0;
        sum_r     = '0;
        sum_g     = '0;
        sum_b     = '0;
        taken     = 0;
        errors    = 0;
        samples   = 0;
        results   = 0;
        unsorted  = 0;
        foreach (per_color[c]) per_color[c] = 0;
    endfunction

    function void set_reg(logic idx, logic [8:0] data);
        if (idx == rgbac_pkg::CFG_SORT_ENABLED)
            sort_en = data[0];
        else
            left_mask = data;
    endfunction

    // accumulate one request; a finished run queues its expected averages and color
    function void note_sample(rgbac_pkg::t_in_req req);
        rgbac_pkg::t_out_res res;
        samples++;
        sum_r = sum_r + {8'd0, swap16(req.red_raw)};
        sum_g = sum_g + {8'd0, swap16(req.green_raw)};
        sum_b = sum_b + {8'd0, swap16(req.blue_raw)};
        taken++;
        if (taken < RUN_LEN)
            return;
        res.avg_red        = 16'(sum_r / RUN_LEN);
        res.avg_green      = 16'(sum_g / RUN_LEN);
        res.avg_blue       = 16'(sum_b / RUN_LEN);
        res.sorting_active = sort_en;
        res.color_code     = rgbac_pkg::COLOR_ABSENT;
        res.direction      = rgbac_pkg::DIR_CENTER;
        if (sort_en) begin
            res.color_code = classify_avg(res.avg_red, res.avg_green, res.avg_blue);
            if (res.color_code != rgbac_pkg::COLOR_ABSENT)
                res.direction = left_mask[res.color_code] ? rgbac_pkg::DIR_LEFT
                                                          : rgbac_pkg::DIR_RIGHT;
        end
        expected_runs.push_back(res);
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        taken = 0;
    endfunction

    function void cmp_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            errors++;
        end
    endfunction

    function void check_result(rgbac_pkg::t_out_res got);
        rgbac_pkg::t_out_res exp_res;
        if (expected_runs.size() == 0) begin
            $error("result with no run pending: color_code %0d avg %0d/%0d/%0d",
                   got.color_code, got.avg_red, got.avg_green, got.avg_blue);
            errors++;
            return;
        end
        exp_res = expected_runs.pop_front();
        results++;
        if (exp_res.sorting_active)
            per_color[exp_res.color_code]++;
        else
            unsorted++;
        cmp_field("color_code", exp_res.color_code, got.color_code);
        cmp_field("direction", exp_res.direction, got.direction);
        cmp_field("avg_red", exp_res.avg_red, got.avg_red);
        cmp_field("avg_green", exp_res.avg_green, got.avg_green);
        cmp_field("avg_blue", exp_res.avg_blue, got.avg_blue);
        cmp_field("sorting_active", exp_res.sorting_active, got.sorting_active);
    endfunction
endclass

module rgb_average_color_classifier_tb;

    localparam int LIMIT = 400000;

    typedef enum {RX_OPEN, RX_COIN, RX_BURSTY} t_rx_mode;

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    rgbac_pkg::t_in_req            i_in_req   = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    rgbac_pkg::t_out_res           o_out_res;
    logic                          i_cfg_we   = 1'b0;
    logic                          i_cfg_idx  = rgbac_pkg::CFG_SORT_ENABLED;
    logic [rgbac_pkg::CFG_W-1:0]   i_cfg_data = '0;

    color_run_scoreboard color_sb;

    logic [15:0] run_vals[3][RUN_LEN];
    int          burst_left = 0;
    int          cycle_count = 0;
    t_rx_mode    rx_mode = RX_OPEN;
    int          rx_left = 0;
    logic        rx_hold = 1'b0;

    rgb_average_color_classifier dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_res   (o_out_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == LIMIT) begin
            $display("cycle limit hit with %0d runs outstanding", color_sb.expected_runs.size());
            $display("rgb_average_color_classifier: mismatch");
            $finish;
        end
    end

    // result side: take results and stall on a changing pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            color_sb.check_result(o_out_res);
        if (cycle_count % 97 == 0) begin
            case ($urandom_range(2, 0))
                0: rx_mode = RX_OPEN;
                1: rx_mode = RX_COIN;
                default: rx_mode = RX_BURSTY;
            endcase
        end
        case (rx_mode)
            RX_OPEN: i_out_ready <= 1'b1;
            RX_COIN: i_out_ready <= ($urandom_range(1, 0) == 1);
            default: begin
                if (rx_left == 0) begin
                    rx_hold = !rx_hold;
                    rx_left = rx_hold ? $urandom_range(8, 1) : $urandom_range(25, 1);
                end
                rx_left--;
                i_out_ready <= rx_hold;
            end
        endcase
    end

    task automatic send_sample(input rgbac_pkg::t_in_req req);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(4, 0) == 0) ? 0 : $urandom_range(12, 1);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(9, 0) == 0) ? $urandom_range(200, 60)
                                                    : $urandom_range(30, 1);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        color_sb.note_sample(req);
    endtask

    task automatic send_run_vals();
        rgbac_pkg::t_in_req req;
        int k;
        for (k = 0; k < RUN_LEN; k++) begin
            req.red_raw   = swap16(run_vals[0][k]);
            req.green_raw = swap16(run_vals[1][k]);
            req.blue_raw  = swap16(run_vals[2][k]);
            send_sample(req);
        end
    endtask

    // hold off requests until every run is out, then let the pipeline settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (color_sb.expected_runs.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [8:0] sort_word, input logic [8:0] mask);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= rgbac_pkg::CFG_SORT_ENABLED;
        i_cfg_data <= sort_word;
        @(posedge i_clk);
        color_sb.set_reg(rgbac_pkg::CFG_SORT_ENABLED, sort_word);
        i_cfg_idx  <= rgbac_pkg::CFG_LEFT_MASK;
        i_cfg_data <= mask;
        @(posedge i_clk);
        color_sb.set_reg(rgbac_pkg::CFG_LEFT_MASK, mask);
        i_cfg_we   <= 1'b0;
    endtask

    // mostly inside the window, sometimes right on or just past an edge
    function automatic int pick_target(int lo, int hi);
        int v;
        if ($urandom_range(3, 0) != 0)
            return $urandom_range(hi, lo);
        case ($urandom_range(3, 0))
            0: v = lo - 1;
            1: v = lo;
            2: v = hi;
            default: v = hi + 1;
        endcase
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v;
    endfunction

    // spread samples in +/- pairs around t so the truncated average lands on t
    function automatic void fill_channel(int ch, int t);
        int lim;
        int d;
        int k;
        lim = (t < 65535 - t) ? t : 65535 - t;
        if (lim > 3000) lim = 3000;
        for (k = 0; k < RUN_LEN; k += 2) begin
            d = $urandom_range(lim, 0);
            run_vals[ch][k] = 16'(t + d);
            if (k + 1 < RUN_LEN) run_vals[ch][k + 1] = 16'(t - d);
        end
        if (t <= 65528 && RUN_LEN > 1)
            run_vals[ch][1] = run_vals[ch][1] + 16'($urandom_range(RUN_LEN - 1, 0));
    endfunction

    task automatic send_random_run();
        int pick;
        int ch;
        int k;
        t_calib_window cw;
        pick = $urandom_range(99, 0);
        if (pick < 70) begin
            cw = calib_window($urandom_range(NUM_WINDOWS - 1, 0));
            fill_channel(0, pick_target(cw.r_lo, cw.r_hi));
            fill_channel(1, pick_target(cw.g_lo, cw.g_hi));
            fill_channel(2, pick_target(cw.b_lo, cw.b_hi));
        end else begin
            for (ch = 0; ch < 3; ch++)
                for (k = 0; k < RUN_LEN; k++) begin
                    if (pick < 90)
                        run_vals[ch][k] = 16'($urandom_range(65535, 0));
                    else
                        case ($urandom_range(2, 0))
                            0: run_vals[ch][k] = 16'h0000;
                            1: run_vals[ch][k] = 16'hFFFF;
                            default: run_vals[ch][k] = 16'($urandom_range(65535, 0));
                        endcase
                end
        end
        send_run_vals();
    endtask

    initial begin
        int runs_left;
        int phase;
        int n;
        int k;
        int seen;
        logic [7:0] junk;
        color_sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all-zero run with the register reset values: sorting off
        for (k = 0; k < RUN_LEN; k++) begin
            run_vals[0][k] = 16'h0000;
            run_vals[1][k] = 16'h0000;
            run_vals[2][k] = 16'h0000;
        end
        send_run_vals();
        drain();

        // full scale with sorting on through a word with junk above bit 0
        write_config(9'h1FF, 9'h155);
        for (k = 0; k < RUN_LEN; k++) begin
            run_vals[0][k] = 16'hFFFF;
            run_vals[1][k] = 16'hFFFF;
            run_vals[2][k] = 16'hFFFF;
        end
        send_run_vals();
        drain();

        // bit 0 clear turns sorting off; averages truncate and bytes must swap
        write_config(9'h1FE, 9'h0AA);
        for (k = 0; k < RUN_LEN; k++) begin
            run_vals[0][k] = 16'(k + 1);
            run_vals[1][k] = k[0] ? 16'h5555 : 16'hAAAA;
            run_vals[2][k] = k[0] ? 16'h00FF : 16'hFF00;
        end
        send_run_vals();
        drain();

        runs_left = 72;
        phase = 0;
        while (runs_left > 0) begin
            junk = 8'($urandom_range(255, 0));
            case (phase)
                0: write_config(9'h001, 9'h000);
                1: write_config(9'h001, 9'h1FF);
                2: write_config({junk, 1'b0}, 9'($urandom_range(511, 0)));
                default: write_config({junk, ($urandom_range(3, 0) != 0)},
                                      9'($urandom_range(511, 0)));
            endcase
            n = $urandom_range(14, 8);
            if (n > runs_left) n = runs_left;
            repeat (n) send_random_run();
            runs_left -= n;
            drain();
            phase++;
        end

        seen = 0;
        for (k = 0; k < 10; k++)
            if (color_sb.per_color[k] != 0) seen++;
        $display("Covered %0d sample requests in %0d runs, %0d of them with sorting off.",
                 color_sb.samples, color_sb.results, color_sb.unsorted);
        $display("Color codes reached with sorting on: %0d of 10, over %0d config phases.",
                 seen, phase + 3);
        if (color_sb.errors == 0)
            $display("rgb_average_color_classifier: match");
        else
            $display("rgb_average_color_classifier: mismatch");
        $finish;
    end

endmodule

// File: filelist.f
design/rgbac_pkg.sv
design/rgbac_accum.sv
design/rgbac_divide.sv
design/rgbac_classify.sv
design/rgb_average_color_classifier.sv
tb/rgb_average_color_classifier_tb.sv
